>>> rtl/cdds_pkg.sv
// ============================================================================
// cdds_pkg: shared definitions for the calendar date day stepper
// Field widths, year limits, month numbers, status codes and the word types
// passed between the stepper's modules.
// ============================================================================
package cdds_pkg;

  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int CNT_W   = 16;
  localparam int STAT_W  = 2;

  localparam logic signed [YEAR_W-1:0] YEAR_MAX = 16'sh7FFF;
  localparam logic signed [YEAR_W-1:0] YEAR_MIN = 16'sh8000;
  localparam logic signed [YEAR_W-1:0] YEAR_ONE = 16'sd1;
  localparam logic signed [YEAR_W-1:0] YEAR_BC1 = -16'sd1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
  } date_t;

  typedef struct packed {
    logic                     action;
    logic signed [YEAR_W-1:0] new_year;
    logic [MONTH_W-1:0]       new_month;
    logic [DAY_W-1:0]         new_day;
    logic signed [CNT_W-1:0]  step_count;
  } in_word_t;

  typedef struct packed {
    date_t   date;
    status_t status;
  } result_t;

endpackage

>>> rtl/cdds_if.sv
// ============================================================================
// cdds_if: valid/ready channels of the calendar date day stepper
// One interface for the command words going in, one for the date words
// coming out.
// ============================================================================
interface cdds_in_if;
  import cdds_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [YEAR_W-1:0] new_year;
  logic [MONTH_W-1:0]       new_month;
  logic [DAY_W-1:0]         new_day;
  logic signed [CNT_W-1:0]  step_count;

  modport source (output valid, action, new_year, new_month, new_day, step_count,
                  input ready);
  modport sink   (input valid, action, new_year, new_month, new_day, step_count,
                  output ready);
endinterface

interface cdds_out_if;
  import cdds_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [YEAR_W-1:0] year;
  logic [MONTH_W-1:0]       month;
  logic [DAY_W-1:0]         day;
  logic [STAT_W-1:0]        status;

  modport source (output valid, year, month, day, status, input ready);
  modport sink   (input valid, year, month, day, status, output ready);
endinterface

>>> rtl/cdds_month_len.sv
// ============================================================================
// cdds_month_len: month length unit
// Gives the number of days in the month of a date, with the proleptic
// Gregorian leap rule and BC years shifted by one.
// ============================================================================
module cdds_month_len (
  input  cdds_pkg::date_t          dt,
  output logic [cdds_pkg::DAY_W-1:0] len
);
  import cdds_pkg::*;

  localparam logic [DAY_W-1:0] LEN_28 = 5'd28;
  localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
  localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
  localparam logic [DAY_W-1:0] LEN_31 = 5'd31;

  // Divisibility by 25 through the modular inverse of 25 modulo 2^16.
  localparam logic [YEAR_W-1:0] INV25 = 16'd23593;
  localparam logic [YEAR_W-1:0] LIM25 = 16'd2621;

  logic signed [YEAR_W-1:0] t;
  logic [YEAR_W-1:0]        t_abs;
  logic [2*YEAR_W-1:0]      prod;
  logic                     div25;
  logic                     leap;

  // BC years count from 1 BC as a leap year, so shift them up by one.
  assign t     = dt.year[YEAR_W-1] ? dt.year + YEAR_ONE : dt.year;
  assign t_abs = t[YEAR_W-1] ? unsigned'(-t) : unsigned'(t);
  assign prod  = t_abs * INV25;
  assign div25 = prod[YEAR_W-1:0] <= LIM25;
  // With four dividing t: a multiple of 100 is a leap year only when
  // sixteen divides it too, which makes it a multiple of 400.
  assign leap  = (t[1:0] == 2'b00) && (!div25 || (t[3:0] == 4'b0000));

  always_comb begin
    case (dt.month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = LEN_30;
      MONTH_FEB:               len = leap ? LEN_29 : LEN_28;
      default:                 len = LEN_31;
    endcase
  end

endmodule

>>> rtl/cdds_ctrl.sv
// ============================================================================
// cdds_ctrl: date register and day step sequencer
// Holds the current date, checks load words and walks the date one day per
// cycle via the shared month length unit; back month turns add a fix state.
// ============================================================================
module cdds_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cdds_pkg::in_word_t         in_word,
  output cdds_pkg::date_t            ml_date,
  input  logic [cdds_pkg::DAY_W-1:0] ml_len,
  input  logic                       slot_free,
  output logic                       res_push,
  output cdds_pkg::result_t          res
);
  import cdds_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_STEP = 5'b00100,
    S_FIX  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  date_t              cur_r, cur_nxt;
  date_t              ld_r, ld_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               back_r, back_nxt;
  status_t            status_r, status_nxt;
  logic               ld_ok;

  assign in_ready = (state_r == S_IDLE);
  assign ml_date  = (state_r == S_LOAD) ? ld_r : cur_r;
  assign res      = '{date: cur_r, status: status_r};
  assign res_push = (state_r == S_DONE) && slot_free;

  assign ld_ok = (ld_r.year != '0) && (ld_r.month >= MONTH_JAN) &&
                 (ld_r.month <= MONTH_DEC) && (ld_r.day >= DAY_FIRST) &&
                 (ld_r.day <= ml_len);

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    ld_nxt     = ld_r;
    cnt_nxt    = cnt_r;
    back_nxt   = back_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ld_nxt     = '{year: in_word.new_year, month: in_word.new_month,
                         day: in_word.new_day};
          back_nxt   = in_word.step_count[CNT_W-1];
          cnt_nxt    = in_word.step_count[CNT_W-1] ? unsigned'(-in_word.step_count)
                                                   : unsigned'(in_word.step_count);
          status_nxt = ST_OK;
          state_nxt  = (in_word.action == ACT_LOAD) ? S_LOAD : S_STEP;
        end
      end
      S_LOAD: begin
        if (ld_ok) begin
          cur_nxt = ld_r;
        end else begin
          status_nxt = ST_BAD_LOAD;
        end
        state_nxt = S_DONE;
      end
      S_STEP: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else if (!back_r) begin
          cnt_nxt = cnt_r - 1'b1;
          if (cur_r.day < ml_len) begin
            cur_nxt.day = cur_r.day + 1'b1;
          end else if (cur_r.month != MONTH_DEC) begin
            cur_nxt.month = cur_r.month + 1'b1;
            cur_nxt.day   = DAY_FIRST;
          end else if (cur_r.year == YEAR_MAX) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_DONE;
          end else begin
            cur_nxt.year  = (cur_r.year == YEAR_BC1) ? YEAR_ONE : cur_r.year + YEAR_ONE;
            cur_nxt.month = MONTH_JAN;
            cur_nxt.day   = DAY_FIRST;
          end
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          if (cur_r.day != DAY_FIRST) begin
            cur_nxt.day = cur_r.day - 1'b1;
          end else if (cur_r.month != MONTH_JAN) begin
            // The previous month's last day is filled in on the next cycle.
            cur_nxt.month = cur_r.month - 1'b1;
            state_nxt     = S_FIX;
          end else if (cur_r.year == YEAR_MIN) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_DONE;
          end else begin
            cur_nxt.year  = (cur_r.year == YEAR_ONE) ? YEAR_BC1 : cur_r.year - YEAR_ONE;
            cur_nxt.month = MONTH_DEC;
            state_nxt     = S_FIX;
          end
        end
      end
      S_FIX: begin
        cur_nxt.day = ml_len;
        state_nxt   = S_STEP;
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '{year: YEAR_ONE, month: MONTH_JAN, day: DAY_FIRST};
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_r     <= ld_nxt;
    cnt_r    <= cnt_nxt;
    back_r   <= back_nxt;
    status_r <= status_nxt;
  end

endmodule

>>> rtl/calendar_date_day_stepper_top.sv
// ============================================================================
// calendar_date_day_stepper_top: proleptic Gregorian date counter
// Holds one date and answers every command word with the resulting date.
// ============================================================================
// Usage:
// The in_ch channel carries command words. With action low the word loads
// new_year, new_month and new_day after a validity check; with action high
// it moves the date by the signed step_count, one day per cycle.
// Every accepted word yields exactly one word on out_ch: the date after the
// command and a status (ok, rejected load, or year range reached).
// A load is checked in its own state before the done state. A step walks
// day by day, with an extra fix-up state for every month boundary crossed
// backwards, where the day is refilled from the month length unit. The
// day-step loop through that unit sets the rate.
// in_ch.ready is high only while the sequencer is idle, one word at a time.
// A finished result sits in the output register; if the receiver stalls,
// the block still takes and works the next word, but holds its result
// until the register frees up.
// Reset (rst_n low, synchronous) sets the date to 1 January of year 1 and
// empties the output register.
// ============================================================================
module calendar_date_day_stepper_top (
  input logic       clk,
  input logic       rst_n,
  cdds_in_if.sink   in_ch,
  cdds_out_if.source out_ch
);
  import cdds_pkg::*;

  in_word_t        in_word;
  date_t           ml_date;
  logic [DAY_W-1:0] ml_len;
  logic            slot_free;
  logic            res_push;
  result_t         res;
  logic            out_valid_r, out_valid_nxt;
  result_t         out_res_r;

  assign in_word = '{action: in_ch.action, new_year: in_ch.new_year,
                     new_month: in_ch.new_month, new_day: in_ch.new_day,
                     step_count: in_ch.step_count};

  // The output register can take a new result when empty or being drained.
  assign slot_free     = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = res_push ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  cdds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_word   (in_word),
    .ml_date   (ml_date),
    .ml_len    (ml_len),
    .slot_free (slot_free),
    .res_push  (res_push),
    .res       (res)
  );

  cdds_month_len u_month_len (
    .dt  (ml_date),
    .len (ml_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.year   = out_res_r.date.year;
  assign out_ch.month  = out_res_r.date.month;
  assign out_ch.day    = out_res_r.date.day;
  assign out_ch.status = out_res_r.status;

endmodule

>>> rtl/cdds_chk.sv
// ============================================================================
// cdds_chk: port-level checks for the calendar date day stepper
// Watches both channels of the top level and flags protocol or date slips.
// ============================================================================
module cdds_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [cdds_pkg::YEAR_W-1:0] out_year,
  input logic [cdds_pkg::MONTH_W-1:0]      out_month,
  input logic [cdds_pkg::DAY_W-1:0]        out_day,
  input logic [cdds_pkg::STAT_W-1:0]       out_status
);
  import cdds_pkg::*;

  // A result word stays offered until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped before it was taken");

  // Once a word is taken the block is busy working on it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the previous word finished");

  // A new result appears only at the end of a busy stretch.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the sequencer was idle");

  // Each reported word: year not 0, month 1 to 12, day 1 or more, known status.
  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year != '0) && (out_month >= MONTH_JAN) &&
                  (out_month <= MONTH_DEC) && (out_day >= DAY_FIRST) &&
                  (out_status != 2'd3))
    else $error("output word holds an impossible date or status");

endmodule

bind calendar_date_day_stepper_top cdds_chk u_cdds_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_year   (out_ch.year),
  .out_month  (out_ch.month),
  .out_day    (out_ch.day),
  .out_status (out_ch.status)
);

>>> verif/tb_calendar_date_day_stepper_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_calendar_date_day_stepper_top: self-checking bench for the date stepper
// Sends load and step command words and mirrors the calendar in the bench.
// Each date word that comes back is checked against the predicted date and
// status. Idling on both channels varies by phase, and one long receiver
// stall forces the block to back up.
// ============================================================================
module tb_calendar_date_day_stepper_top;
  import cdds_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cdds_in_if  in_ch ();
  cdds_out_if out_ch ();

  calendar_date_day_stepper_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock period: 2 ns high, 2 ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Command words waiting to be offered, and the date words predicted for
  // the commands that the block has taken, oldest first.
  in_word_t cmd_backlog[$];
  result_t  date_forecast[$];

  // Idle percentages for the current phase. They are only changed on the
  // falling edge, so the clocked processes always see a settled value.
  int send_idle_pct = 9;
  int recv_idle_pct = 53;

  int mismatch_count = 0;
  int words_taken = 0;

  // Full-range step counts run far longer than the rest, so the random part
  // only gets a handful of them.
  int big_steps_left = 4;

  // Receiver hold-off state: one long stall, counted down in its own process.
  int hold_left = 0;
  bit hold_done = 1'b0;

  // The bench's own copy of the calendar, starting at 1 January of year 1.
  int          cal_year = 1;
  int unsigned cal_month = 1;
  int unsigned cal_day = 1;

  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Gregorian leap rule. BC years are shifted by one, so that 1 BC (year -1)
  // behaves like year 0 and is a leap year.
  function automatic bit leap_year(int y);
    int t;
    t = (y < 0) ? y + 1 : y;
    return ((t % 4 == 0) && (t % 100 != 0)) || (t % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int y);
    case (m)
      4, 6, 9, 11: return 30;
      MONTH_FEB:   return leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // One day forward. Returns 0 and leaves the date alone at 31 December of
  // the highest year. Year 0 does not exist, so 1 BC rolls into 1 AD.
  function automatic bit step_forward();
    if (cal_day < days_in_month(cal_month, cal_year)) begin
      cal_day++;
      return 1'b1;
    end
    if (cal_month != MONTH_DEC) begin
      cal_month++;
      cal_day = DAY_FIRST;
      return 1'b1;
    end
    if (cal_year == YEAR_MAX)
      return 1'b0;
    cal_year++;
    if (cal_year == 0)
      cal_year = YEAR_ONE;
    cal_month = MONTH_JAN;
    cal_day = DAY_FIRST;
    return 1'b1;
  endfunction

  // One day back. Returns 0 and leaves the date alone at 1 January of the
  // lowest year. The day is refilled from the length of the new month.
  function automatic bit step_backward();
    if (cal_day != DAY_FIRST) begin
      cal_day--;
      return 1'b1;
    end
    if (cal_month != MONTH_JAN) begin
      cal_month--;
    end else begin
      if (cal_year == YEAR_MIN)
        return 1'b0;
      cal_year--;
      if (cal_year == 0)
        cal_year = YEAR_BC1;
      cal_month = MONTH_DEC;
    end
    cal_day = days_in_month(cal_month, cal_year);
    return 1'b1;
  endfunction

  // Applies one accepted command word to the bench calendar and returns the
  // date word the block should answer with.
  function automatic result_t advance_calendar(in_word_t w);
    result_t     r;
    status_t     st;
    int          y;
    int          n;
    int unsigned m;
    int unsigned d;
    st = ST_OK;
    if (w.action == ACT_LOAD) begin
      y = w.new_year;
      m = w.new_month;
      d = w.new_day;
      if (y == 0 || m < MONTH_JAN || m > MONTH_DEC || d < DAY_FIRST ||
          d > days_in_month(m, y)) begin
        st = ST_BAD_LOAD;
      end else begin
        cal_year = y;
        cal_month = m;
        cal_day = d;
      end
    end else begin
      n = w.step_count;
      // The rest of the count is dropped once a year limit is hit.
      for (int i = 0; i < n && st == ST_OK; i++)
        if (!step_forward())
          st = ST_RANGE;
      for (int i = 0; i > n && st == ST_OK; i--)
        if (!step_backward())
          st = ST_RANGE;
    end
    r.date.year = cal_year[YEAR_W-1:0];
    r.date.month = cal_month[MONTH_W-1:0];
    r.date.day = cal_day[DAY_W-1:0];
    r.status = st;
    return r;
  endfunction

  // A load word carries random junk in step_count, which must be ignored.
  function automatic in_word_t load_cmd(logic signed [YEAR_W-1:0] y,
                                        logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d);
    in_word_t w;
    w.action = ACT_LOAD;
    w.new_year = y;
    w.new_month = m;
    w.new_day = d;
    w.step_count = CNT_W'($urandom);
    return w;
  endfunction

  // A step word carries random junk in the load fields, which must be ignored.
  function automatic in_word_t step_cmd(logic signed [CNT_W-1:0] n);
    in_word_t w;
    w.action = ACT_STEP;
    w.new_year = YEAR_W'($urandom);
    w.new_month = MONTH_W'($urandom);
    w.new_day = DAY_W'($urandom);
    w.step_count = n;
    return w;
  endfunction

  // Random command word. Mostly short steps and valid loads, so the date
  // wanders across months, leap days, year 0 and the year limits; some loads
  // are fully random and mostly rejected.
  function automatic in_word_t random_cmd();
    int unsigned              pick;
    int                       n;
    int                       y;
    int unsigned              m;
    logic signed [YEAR_W-1:0] y16;
    pick = $urandom_range(99);
    if (pick < 52) begin
      n = (pick < 45) ? int'($urandom_range(400)) : int'($urandom_range(3000));
      if ($urandom_range(1))
        n = -n;
      return step_cmd(CNT_W'(n));
    end
    if (pick < 55 && big_steps_left > 0) begin
      big_steps_left--;
      return step_cmd(CNT_W'($urandom));
    end
    if (pick >= 80)
      return load_cmd(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom));
    // Valid date: the year is anywhere, close to year 0, or close to a limit.
    case ($urandom_range(4))
      0, 1, 2: begin
        y16 = YEAR_W'($urandom);
        y = (y16 == 0) ? 1 : y16;
      end
      3: begin
        y = int'($urandom_range(5)) - 3;
        if (y >= 0)
          y++;
      end
      default: begin
        if ($urandom_range(1))
          y = YEAR_MAX - int'($urandom_range(7));
        else
          y = YEAR_MIN + int'($urandom_range(7));
      end
    endcase
    m = $urandom_range(MONTH_DEC, MONTH_JAN);
    return load_cmd(YEAR_W'(y), MONTH_W'(m), DAY_W'($urandom_range(days_in_month(m, y), 1)));
  endfunction

  // Driver: offers the next word from the backlog and keeps it steady until
  // the block takes it. The prediction is made at the edge of acceptance,
  // from the word that was on the channel.
  in_word_t offered;

  always @(posedge clk) begin : cmd_driver
    in_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        date_forecast.push_back(advance_calendar(offered));
        words_taken <= words_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cmd_backlog.pop_front();
          offered <= nxt;
          in_ch.action <= nxt.action;
          in_ch.new_year <= nxt.new_year;
          in_ch.new_month <= nxt.new_month;
          in_ch.new_day <= nxt.new_day;
          in_ch.step_count <= nxt.step_count;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Once the 10th word has been taken, the receiver shuts its ready for a
  // long stretch. The words around it are short directed ones and the
  // sender keeps offering, so the output register fills, the next word is
  // worked, and the block has to stall its input.
  always @(posedge clk) begin : rx_hold
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_taken == 10) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks every date word taken against the oldest prediction,
  // field by field, and drives ready with random idling.
  always @(posedge clk) begin : date_monitor
    result_t due;
    string   diffs;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (date_forecast.size() == 0) begin
          flag_mismatch($sformatf("date word %0d-%0d-%0d status %0d with none pending",
                                  out_ch.year, out_ch.month, out_ch.day, out_ch.status));
        end else begin
          due = date_forecast.pop_front();
          diffs = "";
          if (out_ch.year !== due.date.year)
            diffs = {diffs, $sformatf(" year %0d (want %0d)", out_ch.year, due.date.year)};
          if (out_ch.month !== due.date.month)
            diffs = {diffs, $sformatf(" month %0d (want %0d)", out_ch.month, due.date.month)};
          if (out_ch.day !== due.date.day)
            diffs = {diffs, $sformatf(" day %0d (want %0d)", out_ch.day, due.date.day)};
          if (out_ch.status !== due.status)
            diffs = {diffs, $sformatf(" status %0d (want %0d)", out_ch.status, due.status)};
          if (diffs != "")
            flag_mismatch({"date word differs:", diffs});
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Phase idle settings: sender/receiver, then swapped, then no idling.
  int send_pct_by_phase[3] = '{9, 53, 0};
  int recv_pct_by_phase[3] = '{53, 9, 0};

  initial begin
    // Every block input is known from time zero.
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD;
    in_ch.new_year = '0;
    in_ch.new_month = '0;
    in_ch.new_day = '0;
    in_ch.step_count = '0;
    out_ch.ready = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words. From reset: a zero step, then back and forth across
    // the missing year 0.
    cmd_backlog.push_back(step_cmd(0));
    cmd_backlog.push_back(step_cmd(-1));
    cmd_backlog.push_back(step_cmd(1));
    // Rejected loads: year 0, month 0 and 15, day 0, day past month end,
    // and 29 February in a century year that is not a leap year.
    cmd_backlog.push_back(load_cmd(0, 5, 5));
    cmd_backlog.push_back(load_cmd(2000, 0, 1));
    cmd_backlog.push_back(load_cmd(2000, 15, 31));
    cmd_backlog.push_back(load_cmd(2000, 2, 0));
    cmd_backlog.push_back(load_cmd(2000, 4, 31));
    cmd_backlog.push_back(load_cmd(1900, 2, 29));
    // Leap days, with the BC shift: 1 BC and 401 BC are leap, 101 BC is not.
    cmd_backlog.push_back(load_cmd(2000, 2, 29));
    cmd_backlog.push_back(step_cmd(1));
    cmd_backlog.push_back(load_cmd(-1, 2, 29));
    cmd_backlog.push_back(step_cmd(-60));
    cmd_backlog.push_back(load_cmd(-101, 2, 29));
    cmd_backlog.push_back(load_cmd(-401, 2, 29));
    // Both year limits, right at the edge and from a few days inside with
    // the largest counts.
    cmd_backlog.push_back(load_cmd(YEAR_MAX, MONTH_DEC, 31));
    cmd_backlog.push_back(step_cmd(1));
    cmd_backlog.push_back(load_cmd(YEAR_MAX, MONTH_DEC, 25));
    cmd_backlog.push_back(step_cmd(16'sh7FFF));
    cmd_backlog.push_back(load_cmd(YEAR_MIN, MONTH_JAN, DAY_FIRST));
    cmd_backlog.push_back(step_cmd(-1));
    cmd_backlog.push_back(load_cmd(YEAR_MIN, MONTH_JAN, 5));
    cmd_backlog.push_back(step_cmd(16'sh8000));
    // Full-length steps that stay in range.
    cmd_backlog.push_back(load_cmd(YEAR_ONE, MONTH_JAN, DAY_FIRST));
    cmd_backlog.push_back(step_cmd(16'sh7FFF));
    cmd_backlog.push_back(step_cmd(16'sh8000));

    // Random words in three phases. Between phases the sender pauses until
    // every date word it is owed has come back.
    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      send_idle_pct = send_pct_by_phase[ph];
      recv_idle_pct = recv_pct_by_phase[ph];
      repeat (25) cmd_backlog.push_back(random_cmd());
      while (cmd_backlog.size() != 0 || date_forecast.size() != 0 || in_ch.valid)
        @(negedge clk);
    end

    // Keep the clock running to catch any stray word from the block.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog: 20 ms is several times the slowest legal run of this stimulus.
  initial begin
    #20_000_000;
    $display("ERROR: run did not finish in time");
    $display("Mismatches found");
    $finish;
  end

endmodule
